FILE: hdl/ias_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ias_pkg
// Shared constants and types for the interval activity selector.
// ----------------------------------------------------------------------------
package ias_pkg;

	localparam int MAX_JOBS  = 64;
	localparam int TIME_BITS = 16;
	localparam int IDX_W     = 6;
	localparam int CNT_W     = $clog2(MAX_JOBS + 1);

	// One stored job: occupancy, times and arrival index.
	typedef struct packed {
		logic                 vld;
		logic [TIME_BITS-1:0] st;
		logic [TIME_BITS-1:0] fin;
		logic [IDX_W-1:0]     idx;
	} job_t;

	// Chain-wide command, broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

endpackage

FILE: hdl/ias_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ias_cell
// One slot of the sorted job chain: keeps its job, takes the new job, or
// takes its left neighbor's job on insert; takes its right neighbor on scan.
// ----------------------------------------------------------------------------
module ias_cell import ias_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  job_t      new_job,
	input  logic      prev_keep,
	input  job_t      prev_job,
	input  job_t      next_job,
	output job_t      job,
	output logic      keep
);

	job_t job_q;

	// ties stay ahead of the new job, so the order is stable by arrival
	assign keep = job_q.vld && (job_q.fin <= new_job.fin);
	assign job  = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q <= '0;
		end else if (ctl.shift) begin
			job_q <= next_job;
		end else if (ctl.ins && !keep) begin
			job_q <= prev_keep ? new_job : prev_job;
		end
	end

endmodule

FILE: hdl/interval_activity_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_activity_selector
// Greedy activity selection over a chain of insertion-sorting cells.
// ----------------------------------------------------------------------------
// Jobs are taken one per cycle while the input is not stalled; each is
// inserted in finish order (ties by arrival) into a chain of MAX_JOBS cells in
// the cycle it arrives. A request marked final closes the set: the chain then
// shifts toward its head one cell per cycle while the output is not stalled,
// and the head is tested against the last chosen finish. The input stays
// stalled until the whole run of held jobs is scanned. Results leave through a
// single output register; each chosen index is held back until the next choice
// (or the end of the scan) so that the last one can carry run_end. Jobs beyond
// MAX_JOBS are dropped, but a dropped final request still starts selection.
// ----------------------------------------------------------------------------
module interval_activity_selector import ias_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [TIME_BITS-1:0] start_time,
	input  logic [TIME_BITS-1:0] finish_time,
	input  logic                 is_final,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [IDX_W-1:0]     job_index,
	output logic                 run_end
);

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     remain_q;
	logic                 first_q;
	logic [TIME_BITS-1:0] last_fin_q;
	logic                 pend_vld_q;
	logic [IDX_W-1:0]     pend_idx_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic                 out_end_q;

	logic      in_acc;
	logic      can_go;
	logic      scan_step;
	logic      scan_done;
	logic      room;
	logic      chosen;
	cell_ctl_t ctl;
	job_t      new_job;
	job_t      head;
	job_t      cell_job  [MAX_JOBS];
	logic      cell_keep [MAX_JOBS];

	assign in_stall = (state_q != ST_LOAD);
	assign in_acc   = in_valid && !in_stall;
	assign room     = (count_q < CNT_W'(MAX_JOBS));
	assign can_go   = !out_valid_q || !out_stall;

	assign scan_step = (state_q == ST_SCAN) && can_go && (remain_q != '0);
	assign scan_done = (state_q == ST_SCAN) && can_go && (remain_q == '0);

	assign new_job.vld = 1'b1;
	assign new_job.st  = start_time;
	assign new_job.fin = finish_time;
	assign new_job.idx = IDX_W'(count_q);

	assign ctl.ins   = in_acc && room;
	assign ctl.shift = scan_step;

	assign head   = cell_job[0];
	assign chosen = first_q || ((head.st >= last_fin_q) && (head.fin != last_fin_q));

	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
		job_t prev_j;
		job_t next_j;
		logic prev_k;

		if (i == 0) begin : g_head
			assign prev_j = new_job;
			assign prev_k = 1'b1;
		end else begin : g_body
			assign prev_j = cell_job[i-1];
			assign prev_k = cell_keep[i-1];
		end

		if (i == MAX_JOBS - 1) begin : g_tail
			assign next_j = '0;
		end else begin : g_link
			assign next_j = cell_job[i+1];
		end

		ias_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_job   (new_job),
			.prev_keep (prev_k),
			.prev_job  (prev_j),
			.next_job  (next_j),
			.job       (cell_job[i]),
			.keep      (cell_keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			remain_q    <= '0;
			first_q     <= 1'b0;
			last_fin_q  <= '0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (is_final) begin
							state_q    <= ST_SCAN;
							remain_q   <= room ? count_q + CNT_W'(1) : count_q;
							count_q    <= '0;
							first_q    <= 1'b1;
							pend_vld_q <= 1'b0;
						end else if (room) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					if (can_go) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (scan_step) begin
						remain_q <= remain_q - CNT_W'(1);
						first_q  <= 1'b0;
						if (chosen) begin
							last_fin_q  <= head.fin;
							pend_vld_q  <= 1'b1;
							out_valid_q <= pend_vld_q;
						end else begin
							out_valid_q <= 1'b0;
						end
					end else if (scan_done) begin
						// last pending choice closes the run
						out_valid_q <= 1'b1;
						pend_vld_q  <= 1'b0;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scan_step && chosen) begin
			pend_idx_q <= head.idx;
			out_idx_q  <= pend_idx_q;
			out_end_q  <= 1'b0;
		end else if (scan_done) begin
			out_idx_q <= pend_idx_q;
			out_end_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign job_index = out_idx_q;
	assign run_end   = out_end_q;

endmodule
